/* hdl/tdtmv_pkg.sv */
// Shared types and constants for the tridiagonal Toeplitz matrix-vector unit.
package tdtmv_pkg;

    localparam int SAMPLE_WIDTH  = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_WIDTH    = 2 * SAMPLE_WIDTH;
    localparam int SUM_WIDTH     = PROD_WIDTH + 2;
    localparam int CFG_IDX_WIDTH = 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [PROD_WIDTH-1:0]   t_prod;
    typedef logic signed [SUM_WIDTH-1:0]    t_sum;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_DIAGONAL_GAIN = 2'd0,
        CFG_SIDE_GAIN     = 2'd1,
        CFG_ADDEND_GAIN   = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_sample alpha;
        t_sample beta;
        t_sample coeff;
    } t_gains;

    // Operands for one output element.
    typedef struct packed {
        t_sample center;
        t_sample left;
        t_sample right;
        t_sample addend;
        logic    last;
    } t_job;

    typedef struct packed {
        t_prod p_center;
        t_prod p_left;
        t_prod p_right;
        t_prod p_addend;
        logic  last;
    } t_prods;

endpackage

/* hdl/tdtmv_seq.sv */
// Element sequencer: holds neighbor state and issues up to two result jobs per request.
module tdtmv_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tdtmv_pkg::t_sample i_vector_sample,
    input  tdtmv_pkg::t_sample i_addend_sample,
    input  logic              i_is_last,
    input  logic              i_job_ready,
    output logic              o_job_valid,
    output tdtmv_pkg::t_job   o_job
);
    import tdtmv_pkg::*;

    logic    r_job_valid, n_job_valid;
    t_job    r_job, n_job;
    logic    r_extra_valid, n_extra_valid;
    t_job    r_extra, n_extra;
    t_sample r_center, n_center;
    t_sample r_left, n_left;
    t_sample r_addend, n_addend;
    logic    r_pending, n_pending;
    logic    r_left_present, n_left_present;
    logic    stage_ready;
    logic    accept;

    assign stage_ready = !r_job_valid || i_job_ready;
    assign o_ready     = stage_ready && !r_extra_valid;
    assign accept      = i_valid && o_ready;

    always_comb begin
        n_job_valid    = r_job_valid;
        n_job          = r_job;
        n_extra_valid  = r_extra_valid;
        n_extra        = r_extra;
        n_center       = r_center;
        n_left         = r_left;
        n_addend       = r_addend;
        n_pending      = r_pending;
        n_left_present = r_left_present;

        if (stage_ready) begin
            n_job_valid = 1'b0;
        end
        if (r_extra_valid && stage_ready) begin
            n_job         = r_extra;
            n_job_valid   = 1'b1;
            n_extra_valid = 1'b0;
        end

        if (accept) begin
            if (r_pending) begin
                n_job.center = r_center;
                n_job.left   = r_left_present ? r_left : '0;
                n_job.right  = i_vector_sample;
                n_job.addend = r_addend;
                n_job.last   = 1'b0;
                n_job_valid  = 1'b1;
                if (i_is_last) begin
                    n_extra.center = i_vector_sample;
                    n_extra.left   = r_center;
                    n_extra.right  = '0;
                    n_extra.addend = i_addend_sample;
                    n_extra.last   = 1'b1;
                    n_extra_valid  = 1'b1;
                    n_pending      = 1'b0;
                    n_left_present = 1'b0;
                end else begin
                    n_left         = r_center;
                    n_left_present = 1'b1;
                    n_center       = i_vector_sample;
                    n_addend       = i_addend_sample;
                end
            end else begin
                n_left_present = 1'b0;
                if (i_is_last) begin
                    n_job.center = i_vector_sample;
                    n_job.left   = '0;
                    n_job.right  = '0;
                    n_job.addend = i_addend_sample;
                    n_job.last   = 1'b1;
                    n_job_valid  = 1'b1;
                end else begin
                    n_center  = i_vector_sample;
                    n_addend  = i_addend_sample;
                    n_pending = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid    <= 1'b0;
            r_extra_valid  <= 1'b0;
            r_pending      <= 1'b0;
            r_left_present <= 1'b0;
        end else begin
            r_job_valid    <= n_job_valid;
            r_extra_valid  <= n_extra_valid;
            r_pending      <= n_pending;
            r_left_present <= n_left_present;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_extra  <= n_extra;
        r_center <= n_center;
        r_left   <= n_left;
        r_addend <= n_addend;
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

endmodule

/* hdl/tdtmv_mul.sv */
// Product stage: four parallel signed multiplies into a product register.
module tdtmv_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdtmv_pkg::t_gains i_gains,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  tdtmv_pkg::t_job   i_job,
    output logic              o_prod_valid,
    input  logic              i_prod_ready,
    output tdtmv_pkg::t_prods o_prods
);
    import tdtmv_pkg::*;

    logic   r_valid;
    t_prods r_prods, n_prods;
    logic   stage_ready;

    assign stage_ready = !r_valid || i_prod_ready;
    assign o_job_ready = stage_ready;

    always_comb begin
        n_prods.p_center = t_prod'(i_gains.alpha) * t_prod'(i_job.center);
        n_prods.p_left   = t_prod'(i_gains.beta)  * t_prod'(i_job.left);
        n_prods.p_right  = t_prod'(i_gains.beta)  * t_prod'(i_job.right);
        n_prods.p_addend = t_prod'(i_gains.coeff) * t_prod'(i_job.addend);
        n_prods.last     = i_job.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (stage_ready) begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready && i_job_valid) begin
            r_prods <= n_prods;
        end
    end

    assign o_prod_valid = r_valid;
    assign o_prods      = r_prods;

endmodule

/* hdl/tdtmv_acc.sv */
// Sum, round half up and saturate stage feeding the output register.
module tdtmv_acc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_prod_valid,
    output logic              o_prod_ready,
    input  tdtmv_pkg::t_prods i_prods,
    output logic              o_valid,
    input  logic              i_ready,
    output tdtmv_pkg::t_sample o_result_value,
    output logic              o_result_last
);
    import tdtmv_pkg::*;

    localparam t_sum HALF    = (FRACTION_BITS > 0) ? t_sum'(1) <<< (FRACTION_BITS - 1) : '0;
    localparam t_sum SAT_MAX = t_sum'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    localparam t_sum SAT_MIN = -SAT_MAX - t_sum'(1);

    logic    r_valid;
    t_sample r_value, n_value;
    logic    r_last;
    t_sum    sum;
    t_sum    rounded;
    logic    stage_ready;

    assign stage_ready  = !r_valid || i_ready;
    assign o_prod_ready = stage_ready;

    always_comb begin
        sum = t_sum'(i_prods.p_center) + t_sum'(i_prods.p_left)
            + t_sum'(i_prods.p_right) + t_sum'(i_prods.p_addend);
        rounded = (sum + HALF) >>> FRACTION_BITS;
        if (rounded > SAT_MAX) begin
            n_value = SAT_MAX[SAMPLE_WIDTH-1:0];
        end else if (rounded < SAT_MIN) begin
            n_value = SAT_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            n_value = rounded[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (stage_ready) begin
            r_valid <= i_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready && i_prod_valid) begin
            r_value <= n_value;
            r_last  <= i_prods.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_value;
    assign o_result_last  = r_last;

endmodule

/* hdl/tridiagonal_toeplitz_matvec.sv */
// Top level: streaming tridiagonal Toeplitz matrix-vector multiply with scaled addend.
// Usage:
//   Slave stream carries one vector element per request: tdata holds v[i] and b[i],
//   tlast marks the final element. Master stream returns
//   out[i] = alpha*v[i] + beta*(v[i-1] + v[i+1]) + coeff*b[i], Q16.16, rounded half up
//   and saturated; tlast marks the final result of the vector.
//   The result for element i leaves when element i+1 is taken; the last element gives
//   two results (one for a one-element vector).
//   Config channel writes alpha (index 0), beta (1), coeff (2); other indexes ignored.
//   Write only while the block is idle. The config channel is always ready.
// Path: a request that completes a result passes the sequencer, product and output
//   registers before master tvalid rises; the second result of a last element
//   follows it through the same registers.
// Throughput: one element per cycle unless stalled; after a last element that closes a
//   vector of two or more, tready waits until the second result is issued as a job.
// Reset: synchronous active-low; clears gains to zero and starts a new vector.
// Stall: a held master side fills the three stages, then drops s_axis_tready;
//   no data is lost.
module tridiagonal_toeplitz_matvec (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] vector_sample, [63:32] addend_sample
    input  logic [2*tdtmv_pkg::SAMPLE_WIDTH-1:0] i_s_axis_tdata,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [31:0] result_value
    output logic [tdtmv_pkg::SAMPLE_WIDTH-1:0]   o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tdtmv_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [tdtmv_pkg::SAMPLE_WIDTH-1:0]   i_cfg_data
);
    import tdtmv_pkg::*;

    t_gains  r_gains, n_gains;
    logic    job_valid, job_ready;
    t_job    job;
    logic    prod_valid, prod_ready;
    t_prods  prods;
    t_sample result_value;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_gains = r_gains;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DIAGONAL_GAIN: n_gains.alpha = i_cfg_data;
                CFG_SIDE_GAIN:     n_gains.beta  = i_cfg_data;
                CFG_ADDEND_GAIN:   n_gains.coeff = i_cfg_data;
                default:           n_gains       = r_gains;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else begin
            r_gains <= n_gains;
        end
    end

    tdtmv_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_vector_sample (i_s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_addend_sample (i_s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .i_is_last       (i_s_axis_tlast),
        .i_job_ready     (job_ready),
        .o_job_valid     (job_valid),
        .o_job           (job)
    );

    tdtmv_mul u_mul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gains      (r_gains),
        .i_job_valid  (job_valid),
        .o_job_ready  (job_ready),
        .i_job        (job),
        .o_prod_valid (prod_valid),
        .i_prod_ready (prod_ready),
        .o_prods      (prods)
    );

    tdtmv_acc u_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_prod_valid   (prod_valid),
        .o_prod_ready   (prod_ready),
        .i_prods        (prods),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_result_value (result_value),
        .o_result_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = result_value;

endmodule
